>>> rtl/core/str_pkg.sv
// shared types and constants for the stepper ramp generator
package str_pkg;

  localparam int SpeedW = 22;
  localparam int PosW = 24;
  localparam int RunW = 17;
  localparam int PeriodW = 16;
  localparam int CmpW = 15;
  localparam int NumerW = 32;
  localparam logic [NumerW-1:0] PeriodNum = 32'd625 << 16;
  localparam logic [RunW-1:0] RunMax = '1;
  localparam logic [SpeedW-1:0] SpeedMax = '1;

  localparam logic [2:0] CfgMinSpeed = 3'd0;
  localparam logic [2:0] CfgMaxSpeed = 3'd1;
  localparam logic [2:0] CfgAccel = 3'd2;
  localparam logic [2:0] CfgDecel = 3'd3;
  localparam logic [2:0] CfgLimit = 3'd4;
  localparam logic [2:0] CfgHomeDir = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_MOVE = 3'd1,
    OP_RUN = 3'd2,
    OP_STOP = 3'd3,
    OP_HOME = 3'd4,
    OP_DIR = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FREE = 2'd1,
    MODE_COUNT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RAMP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic exec;
    logic ramp;
    logic div_start;
    logic div_commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

>>> rtl/core/str_ctrl.sv
// controller state machine sequencing command, ramp and period division
module str_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  str_pkg::sts_t   sts,
  output str_pkg::cmd_t   cmd
);
  import str_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = ST_RAMP;
      end
      ST_RAMP: begin
        cmd.ramp = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_commit = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

>>> rtl/core/str_div.sv
// restoring serial divider for the step period, one quotient bit per cycle
module str_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [str_pkg::SpeedW-1:0] divisor,
  output logic                      done,
  output logic [str_pkg::PeriodW-1:0] period
);
  import str_pkg::*;

  localparam int CntW = $clog2(NumerW + 1);

  logic [NumerW-1:0] quo_r, quo_nxt;
  logic [SpeedW:0] rem_r, rem_nxt;
  logic [SpeedW-1:0] dvs_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [SpeedW:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[SpeedW-1:0], quo_r[NumerW-1]};
    if (start) begin
      quo_nxt = PeriodNum;
      rem_nxt = '0;
      cnt_nxt = CntW'(NumerW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NumerW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = !busy_r && !start;
  always_comb begin
    if (dvs_r == '0 || quo_r[NumerW-1:PeriodW] != '0) period = '1;
    else period = quo_r[PeriodW-1:0];
  end
endmodule

>>> rtl/core/str_dp.sv
// datapath: configuration, motion state, counters and ramp decisions
module str_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [str_pkg::SpeedW-1:0] cfg_data,
  input  logic                       in_accept,
  input  logic [2:0]                 in_opcode,
  input  logic [str_pkg::SpeedW-1:0] in_target_speed,
  input  logic [15:0]                in_target_steps,
  input  logic                       in_direction,
  input  logic                       in_home_sensor,
  input  str_pkg::cmd_t              cmd,
  output str_pkg::sts_t              sts,
  output logic [78:0]                out_word
);
  import str_pkg::*;

  logic [SpeedW-1:0] min_speed_r, max_speed_r;
  logic [15:0] accel_r, decel_r, limit_r;
  logic home_fwd_r;

  logic [2:0] op_r;
  logic [SpeedW-1:0] tspeed_r;
  logic [15:0] tsteps_r;
  logic dir_in_r, sensor_r;

  mode_t mode_r, mode_nxt;
  logic dir_r, dir_nxt, home_r, home_nxt, gen_r, gen_nxt, rel_r, rel_nxt;
  logic [RunW-1:0] run_r, run_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [SpeedW-1:0] speed_r, speed_nxt, goal_speed_r, goal_speed_nxt;
  logic [15:0] goal_steps_r, goal_steps_nxt;
  logic [PeriodW-1:0] period_r;
  logic [CmpW-1:0] cmp_r;
  logic changed_r, changed_nxt, tick_r, tick_nxt, div_req;

  logic div_done;
  logic [PeriodW-1:0] div_period;

  logic [32:0] acc_prod;
  logic signed [23:0] up_room;
  logic signed [23:0] spd_room;
  logic acc;
  logic signed [34:0] dec_prod;
  logic signed [36:0] dec_t;
  logic [SpeedW:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r <= 22'd65536;
      max_speed_r <= 22'd3276800;
      accel_r <= 16'd328;
      decel_r <= 16'd328;
      limit_r <= 16'd40000;
      home_fwd_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMinSpeed: min_speed_r <= cfg_data;
        CfgMaxSpeed: max_speed_r <= cfg_data;
        CfgAccel: accel_r <= cfg_data[15:0];
        CfgDecel: decel_r <= cfg_data[15:0];
        CfgLimit: limit_r <= cfg_data[15:0];
        CfgHomeDir: home_fwd_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= in_opcode;
      tspeed_r <= in_target_speed;
      tsteps_r <= in_target_steps;
      dir_in_r <= in_direction;
      sensor_r <= in_home_sensor;
    end
  end

  assign up_room = $signed({2'b0, goal_speed_r}) - $signed({2'b0, min_speed_r});
  assign spd_room = $signed({2'b0, speed_r}) - $signed({2'b0, min_speed_r});
  assign acc_prod = run_r * accel_r;
  assign acc = ($signed({1'b0, acc_prod}) < $signed({{10{up_room[23]}}, up_room}))
               && (run_r < {2'b0, goal_steps_r[15:1]});
  assign dec_prod = ($signed({1'b0, run_r}) - $signed({2'b0, goal_steps_r}))
                    * $signed({1'b0, decel_r});
  assign dec_t = {{2{dec_prod[34]}}, dec_prod}
                 + {{13{spd_room[23]}}, spd_room};
  assign sum = speed_r + accel_r;

  always_comb begin
    mode_nxt = mode_r;
    dir_nxt = dir_r;
    home_nxt = home_r;
    gen_nxt = gen_r;
    rel_nxt = rel_r;
    run_nxt = run_r;
    pos_nxt = pos_r;
    speed_nxt = speed_r;
    goal_speed_nxt = goal_speed_r;
    goal_steps_nxt = goal_steps_r;
    changed_nxt = changed_r;
    tick_nxt = tick_r;
    div_req = 1'b0;
    if (cmd.exec) begin
      changed_nxt = 1'b0;
      tick_nxt = 1'b0;
      unique case (op_r)
        OP_TICK: begin
          if (gen_r) begin
            tick_nxt = 1'b1;
            if (run_r != RunMax) run_nxt = run_r + 1'b1;
            pos_nxt = dir_r ? pos_r - 1'b1 : pos_r + 1'b1;
            if (sensor_r && dir_r == home_fwd_r) begin
              run_nxt = '0;
              mode_nxt = MODE_STOP;
              gen_nxt = 1'b0;
              rel_nxt = 1'b1;
              pos_nxt = '0;
              home_nxt = 1'b1;
            end
          end
        end
        OP_MOVE: begin
          if (tspeed_r > max_speed_r) goal_speed_nxt = max_speed_r;
          else if (tspeed_r < min_speed_r) goal_speed_nxt = min_speed_r;
          else goal_speed_nxt = tspeed_r;
          goal_steps_nxt = tsteps_r;
          speed_nxt = min_speed_r;
          changed_nxt = 1'b1;
          mode_nxt = MODE_COUNT;
          rel_nxt = 1'b0;
          run_nxt = '0;
          gen_nxt = 1'b1;
        end
        OP_RUN, OP_HOME: begin
          if (op_r == OP_HOME) dir_nxt = home_fwd_r;
          rel_nxt = 1'b0;
          mode_nxt = MODE_FREE;
          goal_steps_nxt = limit_r;
          gen_nxt = 1'b1;
        end
        OP_STOP: begin
          run_nxt = '0;
          mode_nxt = MODE_STOP;
          gen_nxt = 1'b0;
          rel_nxt = 1'b1;
          goal_steps_nxt = '0;
        end
        OP_DIR: dir_nxt = dir_in_r;
        default: ;
      endcase
    end
    if (cmd.ramp) begin
      div_req = changed_r;
      if (tick_r) begin
        if ((mode_r == MODE_COUNT && (run_r >= {1'b0, goal_steps_r}
             || run_r >= {1'b0, limit_r}))
            || (mode_r == MODE_FREE && run_r > {1'b0, limit_r})) begin
          run_nxt = '0;
          mode_nxt = MODE_STOP;
          gen_nxt = 1'b0;
          rel_nxt = 1'b1;
        end else if (mode_r != MODE_STOP) begin
          if (acc) begin
            if (speed_r < goal_speed_r) begin
              speed_nxt = sum[SpeedW] ? SpeedMax : sum[SpeedW-1:0];
              changed_nxt = 1'b1;
              div_req = 1'b1;
            end
          end else if (dec_t > 0 && speed_r > min_speed_r) begin
            speed_nxt = (speed_r > {6'b0, decel_r}) ? speed_r - decel_r : '0;
            changed_nxt = 1'b1;
            div_req = 1'b1;
          end
        end
      end
    end
  end

  assign sts.need_div = div_req;
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STOP;
      dir_r <= 1'b0;
      home_r <= 1'b0;
      gen_r <= 1'b0;
      rel_r <= 1'b1;
      run_r <= '0;
      pos_r <= '0;
      speed_r <= '0;
      goal_speed_r <= '0;
      goal_steps_r <= '0;
      period_r <= 16'd100;
      cmp_r <= 15'd50;
      changed_r <= 1'b0;
      tick_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      dir_r <= dir_nxt;
      home_r <= home_nxt;
      gen_r <= gen_nxt;
      rel_r <= rel_nxt;
      run_r <= run_nxt;
      pos_r <= pos_nxt;
      speed_r <= speed_nxt;
      goal_speed_r <= goal_speed_nxt;
      goal_steps_r <= goal_steps_nxt;
      changed_r <= changed_nxt;
      tick_r <= tick_nxt;
      if (cmd.div_commit) begin
        period_r <= div_period;
        cmp_r <= div_period[PeriodW-1:1];
      end
    end
  end

  str_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (speed_nxt),
    .done    (div_done),
    .period  (div_period)
  );

  assign out_word = {home_r, pos_r, run_r, rel_r, gen_r, dir_r, mode_r,
                     changed_r, cmp_r, period_r};
endmodule

>>> rtl/core/stepper_trapezoid_ramp.sv
// top level of the stepper trapezoidal ramp generator
// flow: an accepted word passes through ST_EXEC and ST_RAMP, then ST_OUT holds the result
// with a period update ST_DIV waits while the serial divider forms 32 quotient bits, then commits
// a new word is accepted only in ST_IDLE, after the previous result has been taken
// reset: synchronous active low; config to defaults, motor stopped, period 100
module stepper_trapezoid_ramp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode, target_speed, target_steps, direction_in, home_sensor
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // step_period, pulse_compare, period_changed, motion_mode, direction_out,
  // step_gen_on, driver_release, run_steps, position_steps, at_home
  output logic [79:0] out_tdata
);
  import str_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [78:0] word;

  str_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  str_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_accept       (in_tvalid && in_tready),
    .in_opcode       (in_tdata[2:0]),
    .in_target_speed (in_tdata[24:3]),
    .in_target_steps (in_tdata[40:25]),
    .in_direction    (in_tdata[41]),
    .in_home_sensor  (in_tdata[42]),
    .cmd             (cmd),
    .sts             (sts),
    .out_word        (word)
  );

  assign out_tdata = {1'b0, word};

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.ramp, cmd.div_commit})) else $error("command overlap");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.exec) else $error("exec missing");
endmodule

>>> test/tb_stepper_trapezoid_ramp.sv
// testbench for the stepper trapezoidal ramp generator with a self-checking predictor
module tb_stepper_trapezoid_ramp;
  import str_pkg::*;

  typedef struct packed {
    logic [15:0] period;
    logic [14:0] compare;
    logic        changed;
    logic [1:0]  mode;
    logic        dir;
    logic        gen;
    logic        rel;
    logic [16:0] run;
    logic [23:0] pos;
    logic        home;
  } ramp_word_t;

  class ramp_scoreboard;
    logic [21:0] min_spd, max_spd;
    logic [15:0] acc_step, dec_step, limit;
    logic        home_fwd;
    logic [1:0]  mode;
    logic        dir, home, gen, rel;
    logic [16:0] run;
    logic [23:0] pos;
    logic [21:0] speed, goal_spd;
    logic [15:0] goal_stp, period;
    logic [14:0] compare;
    ramp_word_t  pending[$];
    int          errors;

    function new();
      min_spd = 65536; max_spd = 3276800; acc_step = 328; dec_step = 328;
      limit = 40000; home_fwd = 0;
      mode = MODE_STOP; dir = 0; home = 0; run = 0; pos = 0; speed = 0;
      goal_spd = 0; goal_stp = 0; period = 100; compare = 50; gen = 0; rel = 1;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [21:0] v);
      case (idx)
        CfgMinSpeed: min_spd = v;
        CfgMaxSpeed: max_spd = v;
        CfgAccel: acc_step = v[15:0];
        CfgDecel: dec_step = v[15:0];
        CfgLimit: limit = v[15:0];
        CfgHomeDir: home_fwd = v[0];
        default: ;
      endcase
    endfunction

    function void new_period();
      longint p;
      if (speed == 0) p = 65535;
      else begin
        p = (longint'(625) << 16) / longint'(speed);
        if (p > 65535) p = 65535;
      end
      period = p[15:0];
      compare = p[15:1];
    endfunction

    function void halt();
      run = 0; mode = MODE_STOP; gen = 0; rel = 1;
    endfunction

    function void start_run();
      rel = 0; mode = MODE_FREE; goal_stp = limit; gen = 1;
    endfunction

    function bit step_tick(logic sensor);
      longint up_room, t, s;
      bit accel;
      if (!gen) return 0;
      if (run != RunMax) run++;
      if (dir) pos--; else pos++;
      if (sensor && dir == home_fwd) begin
        halt(); pos = 0; home = 1;
      end else if (mode == MODE_COUNT) begin
        if (run >= goal_stp || run >= limit) halt();
      end else if (mode == MODE_FREE) begin
        if (run > limit) halt();
      end
      if (mode == MODE_STOP) return 0;
      up_room = longint'(goal_spd) - longint'(min_spd);
      accel = (longint'(run) * longint'(acc_step) < up_room) && (run < (goal_stp >> 1));
      if (accel) begin
        if (speed < goal_spd) begin
          s = longint'(speed) + acc_step;
          speed = (s > SpeedMax) ? SpeedMax : s[21:0];
          new_period();
          return 1;
        end
      end else begin
        t = (longint'(run) - longint'(goal_stp)) * longint'(dec_step)
            + (longint'(speed) - longint'(min_spd));
        if (t > 0 && speed > min_spd) begin
          speed = (speed > dec_step) ? speed - dec_step : 0;
          new_period();
          return 1;
        end
      end
      return 0;
    endfunction

    function void note_input(logic [47:0] d);
      logic [2:0] op;
      logic [21:0] tspd;
      bit chg;
      ramp_word_t w;
      op = d[2:0];
      tspd = d[24:3];
      chg = 0;
      case (op)
        OP_TICK: chg = step_tick(d[42]);
        OP_MOVE: begin
          if (tspd > max_spd) goal_spd = max_spd;
          else if (tspd < min_spd) goal_spd = min_spd;
          else goal_spd = tspd;
          goal_stp = d[40:25];
          speed = min_spd;
          new_period();
          chg = 1;
          mode = MODE_COUNT; rel = 0; run = 0; gen = 1;
        end
        OP_RUN: start_run();
        OP_STOP: begin
          halt(); goal_stp = 0;
        end
        OP_HOME: begin
          dir = home_fwd; start_run();
        end
        OP_DIR: dir = d[41];
        default: ;
      endcase
      w = '{period, compare, chg, mode, dir, gen, rel, run, pos, home};
      pending.push_back(w);
    endfunction

    function void check_result(logic [79:0] d);
      ramp_word_t got, exp_w;
      got = '{d[15:0], d[30:16], d[31], d[33:32], d[34], d[35], d[36], d[53:37],
              d[77:54], d[78]};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", d);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w || d[79] !== 1'b0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp %h got %h", exp_w, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [21:0] cfg_data = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;

  ramp_scoreboard sb;
  int send_idle = 21, recv_idle = 50;
  int quiet = 0;
  int ticks_left = 0;

  stepper_trapezoid_ramp u_top (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_idle);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet > 20000) begin
        $display("FAIL stepper_trapezoid_ramp");
        $finish;
      end
    end
  end

  task automatic send_word(logic [2:0] op, logic [21:0] spd, logic [15:0] stp,
                           logic dir_in, logic sensor);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_tdata <= {5'b0, sensor, dir_in, stp, spd, op};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_input({5'b0, sensor, dir_in, stp, spd, op});
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [21:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [21:0] spd;
    r = $urandom_range(99);
    spd = ($urandom_range(3) == 0) ? 22'($urandom) : 22'($urandom_range(6554, 400000));
    if (r < 70) send_word(OP_TICK, 22'($urandom), 16'($urandom), 1'($urandom),
                          $urandom_range(60) == 0);
    else if (r < 80) send_word(OP_MOVE, spd,
                               ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(200)),
                               1'($urandom), 1'($urandom));
    else if (r < 84) send_word(OP_RUN, 22'($urandom), 16'($urandom), 1'($urandom),
                               1'($urandom));
    else if (r < 87) send_word(OP_STOP, 22'($urandom), 16'($urandom), 1'($urandom),
                               1'($urandom));
    else if (r < 91) send_word(OP_HOME, 22'($urandom), 16'($urandom), 1'($urandom),
                               1'($urandom));
    else if (r < 97) send_word(OP_DIR, 22'($urandom), 16'($urandom), 1'($urandom),
                               1'($urandom));
    else send_word(3'($urandom_range(6, 7)), 22'($urandom), 16'($urandom), 1'($urandom),
                   1'($urandom));
  endtask

  task automatic config_phase(int k);
    case (k)
      0: begin
        write_cfg(CfgMinSpeed, 6554); write_cfg(CfgMaxSpeed, 4194303);
        write_cfg(CfgAccel, 65535); write_cfg(CfgDecel, 1);
        write_cfg(CfgLimit, 1); write_cfg(CfgHomeDir, 1);
      end
      1: begin
        write_cfg(CfgMinSpeed, 4194303); write_cfg(CfgMaxSpeed, 6554);
        write_cfg(CfgAccel, 1); write_cfg(CfgDecel, 65535);
        write_cfg(CfgLimit, 65535); write_cfg(CfgHomeDir, 0);
      end
      default: begin
        write_cfg(CfgMinSpeed, 22'($urandom_range(6554, 100000)));
        write_cfg(CfgMaxSpeed, 22'($urandom_range(100000, 4194303)));
        write_cfg(CfgAccel, 22'($urandom_range(1, 5000)));
        write_cfg(CfgDecel, 22'($urandom_range(1, 5000)));
        write_cfg(CfgLimit, 22'($urandom_range(20, 300)));
        write_cfg(CfgHomeDir, 22'($urandom_range(1)));
      end
    endcase
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: defaults, ticks while stopped, all commands, home stop, extremes
    send_word(OP_TICK, 0, 0, 0, 1);
    send_word(OP_MOVE, 22'h3fffff, 16'hffff, 0, 0);
    send_word(OP_TICK, 0, 0, 1, 0);
    send_word(OP_TICK, 0, 0, 0, 1);
    send_word(OP_MOVE, 0, 6, 1, 1);
    repeat (8) send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_DIR, 0, 0, 1, 0);
    send_word(OP_RUN, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 1);
    send_word(OP_HOME, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 1);
    send_word(3'd6, 22'h3fffff, 16'hffff, 1, 1);
    send_word(3'd7, 0, 0, 0, 0);
    send_word(OP_STOP, 0, 0, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      config_phase(ph);
      if (ph == 2) begin
        send_idle = 50; recv_idle = 21;
      end else if (ph == 4) begin
        send_idle = 0; recv_idle = 0;
      end
      for (int i = 0; i < 280; i++) random_item();
      drain();
    end
    drain();
    if (sb.errors == 0) $display("PASS stepper_trapezoid_ramp");
    else $display("FAIL stepper_trapezoid_ramp");
    $finish;
  end
endmodule
